>>> rtl/kssc_pkg.sv
// ----------------------------------------------------------------------------
// kssc_pkg
// Shared types and constants for the keyword shift substitution cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package kssc_pkg;

	// Alphabet size and ASCII anchors
	localparam logic [4:0] ALPHA_LEN = 5'd26;
	localparam int         ALPHA_N   = 26;
	localparam logic [7:0] LETTER_A  = 8'h41;
	localparam logic [7:0] LETTER_END = 8'h5B; // one past 'Z'

	// Request codes
	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_ENCODE = 2'd2;

	// Key store command
	typedef struct packed {
		logic       clear;
		logic       add;
		logic [4:0] letter;
	} key_cmd_t;

	// Walker control and status
	typedef struct packed {
		logic       start;
		logic [4:0] rank;
	} walk_ctrl_t;

	typedef struct packed {
		logic       done;
		logic [4:0] letter;
	} walk_stat_t;

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_WALK = 4'b0100,
		ST_EMIT = 4'b1000
	} seq_state_t;

endpackage

`default_nettype wire

>>> rtl/kssc_if.sv
// ----------------------------------------------------------------------------
// kssc request and result channels
// Valid/ready channels carrying cipher requests in and cipher bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface kssc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] char_code;

	modport source (output valid, output req_type, output char_code, input ready);
	modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface kssc_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] cipher_char;

	modport source (output valid, output cipher_char, input ready);
	modport sink   (input valid, input cipher_char, output ready);
endinterface

`default_nettype wire

>>> rtl/kssc_key_store.sv
// ----------------------------------------------------------------------------
// kssc_key_store
// Deduplicated key letters, used-letter mask and key length.
// ----------------------------------------------------------------------------
`default_nettype none

module kssc_key_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kssc_pkg::key_cmd_t cmd,
	input  wire logic [4:0]        rd_addr,
	output logic [4:0]             rd_letter,
	output logic [25:0]            used_mask,
	output logic [4:0]             key_count
);

	logic [4:0]  letters_q [kssc_pkg::ALPHA_N];
	logic [25:0] used_q;
	logic [4:0]  count_q;
	logic        add_ok;

	// new letter only if unseen and room left
	assign add_ok = cmd.add && !used_q[cmd.letter] && (count_q < kssc_pkg::ALPHA_LEN);

	// mask and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			used_q  <= '0;
			count_q <= '0;
		end else if (add_ok) begin
			used_q[cmd.letter] <= 1'b1;
			count_q            <= count_q + 5'd1;
		end
	end

	// letter array, no reset
	always_ff @(posedge clk) begin
		if (!cmd.clear && add_ok) begin
			letters_q[count_q] <= cmd.letter;
		end
	end

	assign rd_letter = letters_q[rd_addr];
	assign used_mask = used_q;
	assign key_count = count_q;

endmodule

`default_nettype wire

>>> rtl/kssc_walker.sv
// ----------------------------------------------------------------------------
// kssc_walker
// Finds the rank-th unused letter, testing one alphabet position per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kssc_walker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire kssc_pkg::walk_ctrl_t ctrl,
	input  wire logic [25:0]          used_mask,
	output kssc_pkg::walk_stat_t      stat
);

	logic       busy_q;
	logic [4:0] pos_q;
	logic [4:0] rank_q;
	logic       hit;

	// current position is unused and the remaining rank is zero
	assign hit = busy_q && !used_mask[pos_q] && (rank_q == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			rank_q <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
			rank_q <= ctrl.rank;
		end else if (busy_q) begin
			if (hit) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 5'd1;
				if (!used_mask[pos_q]) begin
					rank_q <= rank_q - 5'd1;
				end
			end
		end
	end

	assign stat.done   = hit;
	assign stat.letter = pos_q;

endmodule

`default_nettype wire

>>> rtl/keyword_shift_substitution_cipher.sv
// ----------------------------------------------------------------------------
// keyword_shift_substitution_cipher
// Keyword substitution cipher with a rotated keyed alphabet.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  plain     in   valid/ready   req_type[1:0], char_code[7:0]
//  cipher    out  valid/ready   cipher_char[7:0]
//  cfg       in   cfg_we        cfg_wdata[4:0] (shift distance)
//
// Clear and add requests are taken while idle. An encode of a non-letter goes
// straight to EMIT, and a letter that falls in the key passes CALC first. The
// byte enters the output register in EMIT once the slot is free. Otherwise the
// walker tests one alphabet position a cycle in WALK until it finds the letter.
// Reset clears key length, mask, shift and the sequencer; key letters are
// unreset. plain.ready is low while an encode is in flight or its result
// cannot yet enter the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_shift_substitution_cipher (
	input  wire logic       clk,
	input  wire logic       arst_n,
	kssc_req_if.sink        plain,
	kssc_res_if.source      cipher,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_wdata
);

	kssc_pkg::seq_state_t state_q;
	kssc_pkg::key_cmd_t   key_cmd;
	kssc_pkg::walk_ctrl_t walk_ctrl;
	kssc_pkg::walk_stat_t walk_stat;

	logic [4:0]  shift_q;
	logic [7:0]  char_q;
	logic [7:0]  res_q;
	logic        out_valid_q;
	logic [7:0]  out_char_q;

	logic        accept;
	logic        in_upper;
	logic [4:0]  in_letter;
	logic [4:0]  shift_mod;
	logic [5:0]  pos_raw;
	logic [4:0]  pos;
	logic [4:0]  rd_letter;
	logic [25:0] used_mask;
	logic [4:0]  key_count;
	logic        in_key;
	logic        slot_free;

	assign plain.ready = (state_q == kssc_pkg::ST_IDLE);
	assign accept      = plain.valid && plain.ready;

	// input decode
	assign in_upper  = (plain.char_code >= kssc_pkg::LETTER_A) &&
	                   (plain.char_code < kssc_pkg::LETTER_END);
	assign in_letter = 5'(plain.char_code - kssc_pkg::LETTER_A);

	assign key_cmd.clear  = accept && (plain.req_type == kssc_pkg::REQ_CLEAR);
	assign key_cmd.add    = accept && (plain.req_type == kssc_pkg::REQ_ADD) && in_upper;
	assign key_cmd.letter = in_letter;

	// sequence position: (j + 26 - d mod 26) mod 26
	always_comb begin
		shift_mod = (shift_q >= kssc_pkg::ALPHA_LEN) ? shift_q - kssc_pkg::ALPHA_LEN : shift_q;
		pos_raw = {1'b0, 5'(char_q - kssc_pkg::LETTER_A)} + {1'b0, kssc_pkg::ALPHA_LEN}
		          - {1'b0, shift_mod};
		pos = (pos_raw >= {1'b0, kssc_pkg::ALPHA_LEN}) ?
		      5'(pos_raw - {1'b0, kssc_pkg::ALPHA_LEN}) : pos_raw[4:0];
	end

	assign in_key          = (pos < key_count);
	assign walk_ctrl.start = (state_q == kssc_pkg::ST_CALC) && !in_key;
	assign walk_ctrl.rank  = pos - key_count;

	kssc_key_store u_key_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (key_cmd),
		.rd_addr   (pos),
		.rd_letter (rd_letter),
		.used_mask (used_mask),
		.key_count (key_count)
	);

	kssc_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (walk_ctrl),
		.used_mask (used_mask),
		.stat      (walk_stat)
	);

	// shift distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (cfg_we) begin
			shift_q <= cfg_wdata;
		end
	end

	assign slot_free = !out_valid_q || cipher.ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kssc_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				kssc_pkg::ST_IDLE: begin
					if (accept && plain.req_type == kssc_pkg::REQ_ENCODE) begin
						state_q <= in_upper ? kssc_pkg::ST_CALC : kssc_pkg::ST_EMIT;
					end
				end
				kssc_pkg::ST_CALC: begin
					state_q <= in_key ? kssc_pkg::ST_EMIT : kssc_pkg::ST_WALK;
				end
				kssc_pkg::ST_WALK: begin
					if (walk_stat.done) begin
						state_q <= kssc_pkg::ST_EMIT;
					end
				end
				kssc_pkg::ST_EMIT: begin
					if (slot_free) begin
						state_q <= kssc_pkg::ST_IDLE;
					end
				end
				default: state_q <= kssc_pkg::ST_IDLE;
			endcase
		end
	end

	// request byte and result byte
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= plain.char_code;
			res_q  <= plain.char_code;
		end else if (state_q == kssc_pkg::ST_CALC && in_key) begin
			res_q <= {3'b000, rd_letter} + kssc_pkg::LETTER_A;
		end else if (state_q == kssc_pkg::ST_WALK && walk_stat.done) begin
			res_q <= {3'b000, walk_stat.letter} + kssc_pkg::LETTER_A;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == kssc_pkg::ST_EMIT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (cipher.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == kssc_pkg::ST_EMIT && slot_free) begin
			out_char_q <= res_q;
		end
	end

	assign cipher.valid       = out_valid_q;
	assign cipher.cipher_char = out_char_q;

endmodule

`default_nettype wire

>>> tb/keyword_shift_substitution_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyword_shift_substitution_cipher_tb
// Drives clear, key-letter and encode requests into the cipher under random
// stalls on both channels and several shift settings. Each cipher byte is
// checked against a local predictor of the keyed, rotated alphabet.
// ----------------------------------------------------------------------------

module keyword_shift_substitution_cipher_tb;

	localparam logic [1:0] REQ_UNUSED    = 2'd3;
	localparam int         CLK_HALF      = 10;
	localparam int         RESET_CYCLES  = 4;
	localparam int         SETTLE_CYCLES = 40;
	localparam int         PHASE_ITEMS   = 36;
	localparam int         IDLE_PERCENT  = 37;
	localparam int         CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
	} cipher_req_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [4:0] cfg_wdata;

	kssc_req_if plain_if ();
	kssc_res_if cipher_if ();

	keyword_shift_substitution_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.plain     (plain_if),
		.cipher    (cipher_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state: key in load order, letters used, key length, shift
	logic [4:0]  key_order [kssc_pkg::ALPHA_N];
	logic [25:0] key_used  = '0;
	int          key_len   = 0;
	logic [4:0]  shift_now = '0;

	cipher_req_t pending_reqs [$];
	logic [7:0]  expected_cipher [$];

	logic no_gaps = 1'b0;
	int   queued_total  = 0;
	int   accepted_reqs = 0;
	int   checked_bytes = 0;
	int   full_key_runs = 0;
	int   shift_writes  = 0;
	int   mismatches    = 0;
	int   cycle_count   = 0;

	// Clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic logic is_letter(input logic [7:0] ch);
		return ch >= kssc_pkg::LETTER_A && ch < kssc_pkg::LETTER_END;
	endfunction

	// Cipher byte for one encode request under the current key and shift
	function automatic logic [7:0] substitute(input logic [7:0] ch);
		int d;
		int pos;
		int rank;
		if (!is_letter(ch))
			return ch;
		d   = int'(shift_now) % kssc_pkg::ALPHA_N;
		pos = (int'(ch - kssc_pkg::LETTER_A) + kssc_pkg::ALPHA_N - d) % kssc_pkg::ALPHA_N;
		if (pos < key_len)
			return kssc_pkg::LETTER_A + 8'(key_order[pos]);
		// past the key: rank among the unused letters
		rank = pos - key_len;
		for (int n = 0; n < kssc_pkg::ALPHA_N; n++) begin
			if (!key_used[n]) begin
				if (rank == 0)
					return kssc_pkg::LETTER_A + 8'(n);
				rank--;
			end
		end
		return kssc_pkg::LETTER_A;
	endfunction

	// Apply one accepted request to the predictor
	task automatic apply_request(input cipher_req_t r);
		int n;
		case (r.req_type)
			kssc_pkg::REQ_CLEAR: begin
				key_used = '0;
				key_len  = 0;
			end
			kssc_pkg::REQ_ADD: begin
				if (is_letter(r.char_code)) begin
					n = int'(r.char_code - kssc_pkg::LETTER_A);
					if (!key_used[n] && key_len < kssc_pkg::ALPHA_N) begin
						key_order[key_len] = 5'(n);
						key_len++;
						key_used[n] = 1'b1;
					end
				end
			end
			kssc_pkg::REQ_ENCODE: begin
				expected_cipher.push_back(substitute(r.char_code));
			end
			default: ;
		endcase
	endtask

	// Request driver
	always @(posedge clk) begin : drive_plain
		logic        handed;
		cipher_req_t nxt;
		if (arst_n) begin
			handed = plain_if.valid && plain_if.ready;
			if (handed) begin
				apply_request(pending_reqs[0]);
				void'(pending_reqs.pop_front());
				accepted_reqs++;
			end
			if (!plain_if.valid || handed) begin
				if (pending_reqs.size() != 0
						&& (no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
					nxt = pending_reqs[0];
					plain_if.valid     <= 1'b1;
					plain_if.req_type  <= nxt.req_type;
					plain_if.char_code <= nxt.char_code;
				end else begin
					plain_if.valid <= 1'b0;
				end
			end
		end
	end

	// Cipher monitor and back-pressure
	always @(posedge clk) begin : check_cipher
		logic [7:0] want;
		if (arst_n) begin
			if (cipher_if.valid && cipher_if.ready) begin
				if (expected_cipher.size() == 0) begin
					report_mismatch($sformatf("unexpected cipher byte %02h",
						cipher_if.cipher_char));
				end else begin
					want = expected_cipher.pop_front();
					checked_bytes++;
					if (cipher_if.cipher_char !== want)
						report_mismatch($sformatf("cipher_char %02h, expected %02h",
							cipher_if.cipher_char, want));
				end
			end
			cipher_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_req(input logic [1:0] t, input logic [7:0] c);
		pending_reqs.push_back('{req_type: t, char_code: c});
		if (t != REQ_UNUSED)
			queued_total++;
	endtask

	function automatic logic [7:0] any_letter();
		return kssc_pkg::LETTER_A + 8'($urandom_range(kssc_pkg::ALPHA_N - 1));
	endfunction

	// One session: mostly key load then encodes, sometimes noise
	task automatic queue_session();
		int roll;
		int n;
		int k;
		int tmp;
		int perm [kssc_pkg::ALPHA_N];
		roll = $urandom_range(99);
		if (roll < 10) begin
			// noise, any request code and any byte
			n = $urandom_range(4, 1);
			repeat (n) queue_req(2'($urandom_range(3)), 8'($urandom_range(255)));
		end else if (roll < 22) begin
			// full 26-letter key in shuffled order
			for (int i = 0; i < kssc_pkg::ALPHA_N; i++)
				perm[i] = i;
			for (int i = kssc_pkg::ALPHA_N - 1; i > 0; i--) begin
				k = $urandom_range(i);
				tmp = perm[i];
				perm[i] = perm[k];
				perm[k] = tmp;
			end
			queue_req(kssc_pkg::REQ_CLEAR, 8'($urandom_range(255)));
			for (int i = 0; i < kssc_pkg::ALPHA_N; i++)
				queue_req(kssc_pkg::REQ_ADD, kssc_pkg::LETTER_A + 8'(perm[i]));
			queue_req(kssc_pkg::REQ_ADD, any_letter());
			n = $urandom_range(12, 6);
			repeat (n) queue_req(kssc_pkg::REQ_ENCODE, any_letter());
			queue_req(kssc_pkg::REQ_ENCODE, 8'($urandom_range(255)));
			full_key_runs++;
		end else begin
			// short key, usually after a clear
			if ($urandom_range(9) != 0)
				queue_req(kssc_pkg::REQ_CLEAR, 8'($urandom_range(255)));
			n = $urandom_range(10);
			repeat (n) begin
				if ($urandom_range(99) < 85)
					queue_req(kssc_pkg::REQ_ADD, any_letter());
				else
					queue_req(kssc_pkg::REQ_ADD, 8'($urandom_range(255)));
				if ($urandom_range(19) == 0)
					queue_req(REQ_UNUSED, 8'($urandom_range(255)));
			end
			n = $urandom_range(10, 3);
			repeat (n) begin
				if ($urandom_range(99) < 85)
					queue_req(kssc_pkg::REQ_ENCODE, any_letter());
				else
					queue_req(kssc_pkg::REQ_ENCODE, 8'($urandom_range(255)));
			end
		end
	endtask

	// Wait for all requests and cipher bytes, then let the block settle
	task automatic wait_drained();
		@(negedge clk);
		while (pending_reqs.size() != 0 || plain_if.valid || expected_cipher.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_shift(input logic [4:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		shift_now = v;
		shift_writes++;
	endtask

	// Stimulus and end of run
	initial begin : stimulus
		logic [4:0] plan [7];
		logic [4:0] v;
		int         phase_base;
		plan = '{5'd25, 5'd31, 5'd26, 5'd0, 5'd13, 5'd1, 5'd24};
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		plain_if.valid     = 1'b0;
		plain_if.req_type  = kssc_pkg::REQ_CLEAR;
		plain_if.char_code = '0;
		cipher_if.ready    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty key, byte extremes, ignored loads, repeats, clear
		queue_req(kssc_pkg::REQ_ENCODE, "A");
		queue_req(kssc_pkg::REQ_ENCODE, "Z");
		queue_req(kssc_pkg::REQ_ENCODE, " ");
		queue_req(kssc_pkg::REQ_ENCODE, 8'h00);
		queue_req(kssc_pkg::REQ_ENCODE, 8'hFF);
		queue_req(kssc_pkg::REQ_ENCODE, 8'h40);
		queue_req(kssc_pkg::REQ_ENCODE, 8'h5B);
		queue_req(kssc_pkg::REQ_ENCODE, "a");
		queue_req(kssc_pkg::REQ_ADD, 8'h40);
		queue_req(kssc_pkg::REQ_ADD, "a");
		queue_req(kssc_pkg::REQ_ADD, 8'hFF);
		queue_req(kssc_pkg::REQ_ADD, "Z");
		queue_req(kssc_pkg::REQ_ADD, "E");
		queue_req(kssc_pkg::REQ_ADD, "B");
		queue_req(kssc_pkg::REQ_ADD, "E");
		queue_req(REQ_UNUSED, "Q");
		queue_req(kssc_pkg::REQ_ENCODE, "A");
		queue_req(kssc_pkg::REQ_ENCODE, "D");
		queue_req(kssc_pkg::REQ_ENCODE, "Z");
		queue_req(kssc_pkg::REQ_ENCODE, "M");
		queue_req(kssc_pkg::REQ_CLEAR, 8'h00);
		queue_req(kssc_pkg::REQ_ENCODE, "D");
		queue_req(kssc_pkg::REQ_ADD, "Q");
		queue_req(kssc_pkg::REQ_ENCODE, "A");
		queue_req(REQ_UNUSED, 8'hFF);
		queue_req(kssc_pkg::REQ_CLEAR, 8'hFF);
		wait_drained();

		// random phases, one shift setting each
		for (int ph = 0; ph < 10; ph++) begin
			v = (ph < 7) ? plan[ph] : 5'($urandom_range(31));
			write_shift(v);
			no_gaps = (ph == 3);
			@(negedge clk);
			phase_base = queued_total;
			while (queued_total - phase_base < PHASE_ITEMS)
				queue_session();
			wait_drained();
		end
		no_gaps = 1'b0;

		$display("covered %0d requests, %0d cipher bytes checked, %0d full-key loads",
			accepted_reqs, checked_bytes, full_key_runs);
		$display("shift register written %0d times, %0d mismatches", shift_writes,
			mismatches);
		if (mismatches == 0 && expected_cipher.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> keyword_shift_substitution_cipher.f
rtl/kssc_pkg.sv
rtl/kssc_if.sv
rtl/kssc_key_store.sv
rtl/kssc_walker.sv
rtl/keyword_shift_substitution_cipher.sv
tb/keyword_shift_substitution_cipher_tb.sv
